// ----- rtl/core/fca_pkg.sv -----
`default_nettype none
package fca_pkg;
  localparam int ENTRIES_DEF = 4096;
  localparam int ROOT_DEF = 1;
  localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
  localparam logic [12:0] TABLE_LENGTH_RESET = 13'd4096;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_RD_WAIT,
    ST_DISPATCH,
    ST_ALLOC,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_SPLICE,
    ST_REM_PREV,
    ST_WALK,
    ST_WALK_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_FETCH,
    CMD_READ_CL,
    CMD_ALLOC,
    CMD_SCAN_RD,
    CMD_SCAN_CHK,
    CMD_SPLICE,
    CMD_REM_PREV,
    CMD_WALK_RD,
    CMD_WALK_FREE,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic full;
    logic scan_hit;
    logic scan_end;
    logic walk_end;
    logic rem_none;
    logic has_prev;
  } status_t;
endpackage
`default_nettype wire

// ----- rtl/core/fca_if.sv -----
`default_nettype none
interface fca_in_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [11:0] cluster;
  logic [11:0] prev_cluster;
  logic [31:0] owner;
  modport source(output valid, func, cluster, prev_cluster, owner, input ready);
  modport sink(input valid, func, cluster, prev_cluster, owner, output ready);
endinterface

interface fca_out_if;
  logic valid;
  logic ready;
  logic [15:0] cluster_out;
  logic [31:0] owner_out;
  logic ok;
  modport source(output valid, cluster_out, owner_out, ok, input ready);
  modport sink(input valid, cluster_out, owner_out, ok, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fat_chain_allocator.sv -----
// Channel | Direction | Beat contents
// in_ch   | sink      | func, cluster, prev_cluster, owner
// out_ch  | source    | cluster_out, owner_out, ok
// One item is in flight at a time. A read, a remove of nothing or a failed
// allocation goes through the table read and dispatch to the result beat; an
// allocation adds a read and a check per entry the free scan visits; a remove
// adds a read and a free per freed cluster, set by the registered read port.
// After reset a clearing pass writes all ENTRIES table entries, one per cycle.
// A stalled result holds until it is taken.
`default_nettype none
module fat_chain_allocator #(
  parameter int ENTRIES = fca_pkg::ENTRIES_DEF,
  parameter int ROOT_CLUSTER = fca_pkg::ROOT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  fca_in_if.sink in_ch,
  fca_out_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [12:0] cfg_data
);
  import fca_pkg::*;
  logic [12:0] table_length;
  cmd_t cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) table_length <= TABLE_LENGTH_RESET;
    else if (cfg_we) table_length <= cfg_data;
  end

  fca_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .func(in_ch.func), .status, .cmd
  );

  fca_datapath #(.ENTRIES(ENTRIES), .ROOT_CLUSTER(ROOT_CLUSTER)) u_dp (
    .clk, .rst, .cmd, .table_length,
    .func(in_ch.func), .cluster(in_ch.cluster),
    .prev_cluster(in_ch.prev_cluster), .owner(in_ch.owner),
    .status, .cluster_out(out_ch.cluster_out),
    .owner_out(out_ch.owner_out), .ok(out_ch.ok)
  );
endmodule
`default_nettype wire

// ----- rtl/core/fca_datapath.sv -----
`default_nettype none
module fca_datapath #(
  parameter int ENTRIES = fca_pkg::ENTRIES_DEF,
  parameter int ROOT_CLUSTER = fca_pkg::ROOT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire fca_pkg::cmd_t cmd,
  input  wire logic [12:0] table_length,
  input  wire logic [1:0] func,
  input  wire logic [11:0] cluster,
  input  wire logic [11:0] prev_cluster,
  input  wire logic [31:0] owner,
  output fca_pkg::status_t status,
  output logic [15:0] cluster_out,
  output logic [31:0] owner_out,
  output logic ok
);
  import fca_pkg::*;
  localparam int AW = $clog2(ENTRIES);
  localparam int HW = AW + 1;

  logic [15:0] link_mem [ENTRIES];
  logic [31:0] own_mem [ENTRIES];
  logic [15:0] link_q;
  logic [31:0] own_q;

  logic [1:0] f;
  logic [11:0] cl, pv;
  logic [31:0] who;
  logic [HW-1:0] hint, low, ptr;
  logic none;
  logic [15:0] old_link, cur;
  logic [HW:0] steps;

  logic [HW-1:0] bound;
  logic [HW-1:0] cl_ext, pv_ext;
  logic cl_in, pv_in;

  logic we_l, we_o;
  logic [AW-1:0] wa_l, wa_o, ra;
  logic [15:0] wd_l;
  logic [31:0] wd_o;

  always_comb begin
    if (32'(table_length) < ENTRIES) bound = HW'(table_length);
    else bound = HW'(ENTRIES);
    cl_ext = HW'(cl);
    pv_ext = HW'(pv);
    cl_in = 32'(cl) < ENTRIES;
    pv_in = 32'(pv) < ENTRIES;
  end

  always_comb begin
    we_l = 1'b0; we_o = 1'b0;
    wa_l = ptr[AW-1:0]; wa_o = ptr[AW-1:0];
    wd_l = '0; wd_o = '0;
    ra = ptr[AW-1:0];
    case (cmd)
      CMD_CLEAR: begin
        we_l = 1'b1; we_o = 1'b1;
        wd_l = (ptr == HW'(ROOT_CLUSTER)) ? END_OF_CHAIN : 16'd0;
      end
      CMD_FETCH, CMD_READ_CL: ra = AW'(cl);
      CMD_ALLOC: begin
        we_l = 1'b1; we_o = 1'b1;
        wa_l = hint[AW-1:0]; wa_o = hint[AW-1:0];
        wd_o = who;
        wd_l = END_OF_CHAIN;
      end
      CMD_SCAN_CHK: begin
        we_l = (f != FUNC_READ) && cl != 12'd0 && cl_in && (cl_ext != hint);
        wa_l = AW'(cl);
        wd_l = 16'(hint);
      end
      CMD_SPLICE: begin
        we_l = (f == FUNC_INSERT) && cl != 12'd0;
        wa_l = cluster_out[AW-1:0];
        wd_l = old_link;
      end
      CMD_REM_PREV: begin
        we_l = pv_in; wa_l = AW'(pv); wd_l = END_OF_CHAIN;
      end
      CMD_WALK_RD: ra = cur[AW-1:0];
      CMD_WALK_FREE: begin
        we_l = 1'b1; we_o = 1'b1;
        wa_l = cur[AW-1:0]; wa_o = cur[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_l) link_mem[wa_l] <= wd_l;
    if (we_o) own_mem[wa_o] <= wd_o;
    link_q <= link_mem[ra];
    own_q <= own_mem[ra];
  end

  always_comb begin
    status.clear_done = (ptr == HW'(ENTRIES - 1));
    status.full = (hint == '0) || (hint >= bound);
    status.scan_hit = (link_q == 16'd0);
    status.scan_end = (ptr + HW'(1) >= bound);
    status.walk_end = (cur == END_OF_CHAIN) || (cur == 16'd0) ||
                      (32'(cur) >= ENTRIES) || (32'(steps) >= ENTRIES);
    status.rem_none = (cl == 12'd0) || !cl_in || (link_q == 16'd0);
    status.has_prev = (pv != 12'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      hint <= HW'(ROOT_CLUSTER + 1);
    end else begin
      case (cmd)
        CMD_CLEAR: begin
          ptr <= ptr + HW'(1);
          hint <= HW'(ROOT_CLUSTER + 1);
        end
        CMD_LOAD: begin
          f <= func; cl <= cluster; pv <= prev_cluster; who <= owner;
          ptr <= '0;
        end
        CMD_READ_CL: begin
          old_link <= cl_in ? link_q : 16'd0;
          cur <= 16'(cl);
          low <= hint; none <= (hint == '0); steps <= '0;
          if (f == FUNC_READ) begin
            cluster_out <= cl_in ? link_q : 16'd0;
            owner_out <= cl_in ? own_q : 32'd0;
            ok <= 1'b1;
          end else if (f == FUNC_REMOVE) begin
            cluster_out <= '0; owner_out <= '0; ok <= 1'b1;
          end else begin
            cluster_out <= '0; owner_out <= '0; ok <= 1'b0;
          end
        end
        CMD_ALLOC: begin
          cluster_out <= 16'(hint); ok <= 1'b1;
          ptr <= hint;
        end
        CMD_SCAN_CHK: begin
          if (status.scan_hit) hint <= ptr;
          else if (status.scan_end) hint <= '0;
          else ptr <= ptr + HW'(1);
        end
        CMD_WALK_FREE: begin
          cur <= link_q;
          steps <= steps + (HW+1)'(1);
          if (none || HW'(cur) < low) begin
            low <= HW'(cur); none <= 1'b0;
          end
        end
        CMD_FINISH: if (f == FUNC_REMOVE) hint <= low;
        default: ;
      endcase
    end
  end

  logic unused;
  assign unused = cl_ext[0] ^ pv_ext[0];
endmodule
`default_nettype wire

// ----- rtl/core/fca_ctrl.sv -----
`default_nettype none
module fca_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire logic [1:0] func,
  input  wire fca_pkg::status_t status,
  output fca_pkg::cmd_t cmd
);
  import fca_pkg::*;
  state_t state, state_next;
  logic [1:0] f;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      f <= FUNC_READ;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) f <= func;
    end
  end

  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd = CMD_CLEAR;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd = CMD_FETCH;
        state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        cmd = CMD_READ_CL;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (f == FUNC_READ) state_next = ST_DONE;
        else if (f == FUNC_REMOVE) begin
          if (status.rem_none) state_next = ST_DONE;
          else state_next = ST_REM_PREV;
        end else if (status.full) state_next = ST_DONE;
        else state_next = ST_ALLOC;
      end
      ST_ALLOC: begin
        cmd = CMD_ALLOC;
        state_next = ST_SCAN;
      end
      ST_SCAN: state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT: begin
        cmd = CMD_SCAN_CHK;
        if (status.scan_hit || status.scan_end) state_next = ST_SPLICE;
        else state_next = ST_SCAN;
      end
      ST_SPLICE: begin
        cmd = CMD_SPLICE;
        state_next = ST_DONE;
      end
      ST_REM_PREV: begin
        if (status.has_prev) cmd = CMD_REM_PREV;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_end) begin
          cmd = CMD_FINISH;
          state_next = ST_DONE;
        end else begin
          cmd = CMD_WALK_RD;
          state_next = ST_WALK_WAIT;
        end
      end
      ST_WALK_WAIT: begin
        cmd = CMD_WALK_FREE;
        state_next = ST_WALK;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/fca_checker.sv -----
`default_nettype none
module fca_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] cluster_out,
  input wire logic ok
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cluster_out))
    else $error("result dropped under stall");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> cluster_out == 16'd0)
    else $error("failed allocation returned a cluster");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind fat_chain_allocator fca_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .cluster_out(out_ch.cluster_out), .ok(out_ch.ok)
);
`default_nettype wire

// ----- verif/fca_tb_if.sv -----
`timescale 1ns / 1ps
// Request and answer records shared by the stimulus and the predictor.
package fca_tb_pkg;
  import fca_pkg::*;

  typedef struct {
    func_t       func;
    logic [11:0] cluster;
    logic [11:0] prev_cluster;
    logic [31:0] owner;
  } request_t;

  typedef struct packed {
    logic [15:0] cluster_out;
    logic [31:0] owner_out;
    logic        ok;
  } answer_t;
endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import fca_pkg::*;
  import fca_tb_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1350;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [12:0] cfg_data = '0;

  fca_in_if in_ch ();
  fca_out_if out_ch ();

  fat_chain_allocator u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic [15:0] fat_link [ENTRIES];
  logic [31:0] fat_owner [ENTRIES];
  int unsigned alloc_hint;
  int unsigned length_reg;
  answer_t pending_answers[$];
  int errors = 0;
  bit long_hold = 1'b0;

  function automatic int unsigned live_bound();
    return length_reg < ENTRIES ? length_reg : ENTRIES;
  endfunction

  function automatic int unsigned fat_take(int unsigned after, logic [31:0] who);
    int unsigned got;
    got = alloc_hint;
    if (got == 0 || got >= live_bound()) return 0;
    if (after != 0 && after < ENTRIES) fat_link[after] = 16'(got);
    fat_link[got] = END_OF_CHAIN;
    fat_owner[got] = who;
    alloc_hint = 0;
    for (int unsigned i = got; i < live_bound(); i++) begin
      if (fat_link[i] == 16'h0) begin
        alloc_hint = i;
        break;
      end
    end
    return got;
  endfunction

  function automatic answer_t fat_apply(request_t r);
    answer_t a;
    int unsigned c, old, cur, nxt, low, steps;
    bit none;
    c = r.cluster;
    a.cluster_out = '0;
    a.owner_out = '0;
    a.ok = 1'b1;
    case (r.func)
      FUNC_APPEND: begin
        a.cluster_out = 16'(fat_take(c, r.owner));
        a.ok = a.cluster_out != 0;
      end
      FUNC_INSERT: begin
        old = fat_link[c];
        a.cluster_out = 16'(fat_take(c, r.owner));
        a.ok = a.cluster_out != 0;
        if (a.ok && c != 0) fat_link[a.cluster_out] = 16'(old);
      end
      FUNC_REMOVE: begin
        if (c != 0 && fat_link[c] != 0) begin
          if (r.prev_cluster != 0) fat_link[r.prev_cluster] = END_OF_CHAIN;
          cur = c;
          low = alloc_hint;
          none = alloc_hint == 0;
          steps = 0;
          while (cur != END_OF_CHAIN && cur != 0 && cur < ENTRIES && steps < ENTRIES) begin
            nxt = fat_link[cur];
            fat_link[cur] = '0;
            fat_owner[cur] = '0;
            if (none || cur < low) begin
              low = cur;
              none = 1'b0;
            end
            cur = nxt;
            steps++;
          end
          alloc_hint = low;
        end
      end
      default: begin
        a.cluster_out = fat_link[c];
        a.owner_out = fat_owner[c];
      end
    endcase
    return a;
  endfunction

  task automatic send_beat(request_t r);
    int unsigned gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= r.func;
    in_ch.cluster <= r.cluster;
    in_ch.prev_cluster <= r.prev_cluster;
    in_ch.owner <= r.owner;
    do @(posedge clk); while (!in_ch.ready);
    pending_answers.push_back(fat_apply(r));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_length(int unsigned v);
    cfg_we <= 1'b1;
    cfg_data <= 13'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    length_reg = v;
    @(posedge clk);
  endtask

  function automatic request_t mk(func_t f, int unsigned c, int unsigned p, logic [31:0] o);
    request_t r;
    r.func = f;
    r.cluster = 12'(c);
    r.prev_cluster = 12'(p);
    r.owner = o;
    return r;
  endfunction

  // Random clusters lean toward the low end of the table so chains are hit.
  function automatic int unsigned pick_cluster();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, alloc_hint + 4 < 4096 ? alloc_hint + 4 : 4095);
  endfunction

  // Directed rows: the expected answer is checked here where it is obvious.
  typedef struct {
    request_t req;
    bit       known;
    answer_t  ans;
  } row_t;

  initial begin
    row_t rows[$];
    row_t rw;
    request_t r;
    answer_t a;
    int unsigned lens[5] = '{4096, 2, 5, 6000, 40};

    in_ch.valid = 1'b0;
    in_ch.func = FUNC_APPEND;
    in_ch.cluster = '0;
    in_ch.prev_cluster = '0;
    in_ch.owner = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      fat_link[i] = '0;
      fat_owner[i] = '0;
    end
    fat_link[ROOT_DEF] = END_OF_CHAIN;
    alloc_hint = ROOT_DEF + 1;
    length_reg = TABLE_LENGTH_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rw.known = 1'b1;
    rw.req = mk(FUNC_READ, ROOT_DEF, 0, 0);
    rw.ans = '{END_OF_CHAIN, 32'h0, 1'b1};
    rows.push_back(rw);
    rw.req = mk(FUNC_READ, 0, 0, 0);
    rw.ans = '{16'h0, 32'h0, 1'b1};
    rows.push_back(rw);
    rw.req = mk(FUNC_APPEND, ROOT_DEF, 0, 32'hFFFF_FFFF);
    rw.ans = '{16'd2, 32'h0, 1'b1};
    rows.push_back(rw);
    rw.req = mk(FUNC_READ, 2, 0, 0);
    rw.ans = '{END_OF_CHAIN, 32'hFFFF_FFFF, 1'b1};
    rows.push_back(rw);
    rw.req = mk(FUNC_REMOVE, 0, 5, 0);
    rw.ans = '{16'h0, 32'h0, 1'b1};
    rows.push_back(rw);
    rw.known = 1'b0;
    rw.req = mk(FUNC_INSERT, ROOT_DEF, 0, 32'h1234_5678);
    rows.push_back(rw);
    rw.req = mk(FUNC_INSERT, 0, 0, 32'h0);
    rows.push_back(rw);
    rw.req = mk(FUNC_APPEND, 0, 4095, 32'hA5A5_5A5A);
    rows.push_back(rw);
    rw.req = mk(FUNC_READ, 4095, 0, 0);
    rows.push_back(rw);
    rw.req = mk(FUNC_REMOVE, 3, ROOT_DEF, 0);
    rows.push_back(rw);
    rw.req = mk(FUNC_REMOVE, 4095, 4095, 0);
    rows.push_back(rw);
    rw.req = mk(FUNC_APPEND, 4095, 0, 32'h8000_0001);
    rows.push_back(rw);
    rw.req = mk(FUNC_READ, 3, 0, 0);
    rows.push_back(rw);

    foreach (rows[i]) begin
      send_beat(rows[i].req);
      if (rows[i].known) begin
        a = pending_answers[$];
        if (a != rows[i].ans) begin
          $error("directed row %0d: expected %p, predicted %p", i, rows[i].ans, a);
          errors++;
        end
      end
    end
    drain();

    // A small table fills quickly, so full and refill both get exercised.
    foreach (lens[k]) begin
      write_length(lens[k]);
      if (k == 2) long_hold = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
        int unsigned sel;
        sel = $urandom_range(0, 9);
        r = mk(sel < 3 ? FUNC_APPEND : sel < 5 ? FUNC_INSERT : sel < 7 ? FUNC_REMOVE : FUNC_READ,
               pick_cluster(), $urandom_range(0, 3) == 0 ? pick_cluster() : 0, $urandom());
        send_beat(r);
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int hold;
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
      end
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.cluster_out !== want.cluster_out) begin
          $error("cluster_out expected %0d actual %0d", want.cluster_out, out_ch.cluster_out);
          errors++;
        end
        if (out_ch.owner_out !== want.owner_out) begin
          $error("owner_out expected %h actual %h", want.owner_out, out_ch.owner_out);
          errors++;
        end
        if (out_ch.ok !== want.ok) begin
          $error("ok expected %0d actual %0d", want.ok, out_ch.ok);
          errors++;
        end
      end
    end
  end

  initial begin
    #(64'd400_000_000);
    $display("status: fail");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/fca_pkg.sv
rtl/core/fca_if.sv
rtl/core/fca_datapath.sv
rtl/core/fca_ctrl.sv
rtl/core/fat_chain_allocator.sv
rtl/core/fca_checker.sv
verif/fca_tb_if.sv
verif/testbench.sv
